### rtl/fmt_pkg.sv
// package: types and constants for the modular exponentiation tester
`timescale 1ns / 1ps
`default_nettype none
package fmt_pkg;
	localparam int MOD_WIDTH_DEF = 32;
	localparam int EXP_BITS = 32;

	typedef struct packed {
		logic        mode;
		logic [31:0] base_or_random;
		logic [31:0] exponent;
		logic [31:0] modulus;
	} in_item_t;

	typedef struct packed {
		logic [31:0] power_result;
		logic        probable_prime;
		logic        bad_modulus;
	} out_item_t;

	// remainder unit operations
	localparam logic [1:0] OP_WIT = 2'd0;
	localparam logic [1:0] OP_ACC = 2'd1;
	localparam logic [1:0] OP_SQ  = 2'd2;
	localparam logic [1:0] OP_RED = 2'd3;

	typedef struct packed {
		logic       load;
		logic       start;
		logic [1:0] op;
		logic       shift_exp;
		logic       finish;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic exp_bit;
		logic exp_done;
		logic trivial;
	} sts_t;
endpackage
`default_nettype wire

### rtl/fmt_datapath.sv
// datapath: operand registers, multiplier and bit-serial remainder unit
`timescale 1ns / 1ps
`default_nettype none
module fmt_datapath #(
	parameter int MOD_WIDTH = fmt_pkg::MOD_WIDTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire fmt_pkg::in_item_t  item,
	input  wire fmt_pkg::cmd_t      cmd,
	output fmt_pkg::sts_t           sts,
	output fmt_pkg::out_item_t      result
);
	import fmt_pkg::*;
	localparam int W = MOD_WIDTH;
	localparam int PW = W + 32;
	localparam int CW = $clog2(PW + 1);

	logic          mode_q;
	logic [W-1:0]  m_q, acc_q, sq_q;
	logic [31:0]   bor_q;
	logic [31:0]   exp_q;
	logic [5:0]    ecnt_q;
	logic [PW-1:0] num_q;
	logic [W:0]    rem_q;
	logic [CW-1:0] rcnt_q;
	logic          busy_q;
	logic [1:0]    op_q;
	logic [W-1:0]  div_q;
	logic [PW-1:0] prod;
	logic [2*W-1:0] prod_ac, prod_ss;
	logic [W:0]    trial;
	logic [W:0]    rem_sh;
	logic [W-1:0]  m_in;

	assign m_in = item.modulus[W-1:0];
	assign rem_sh = {rem_q[W-1:0], num_q[PW-1]};
	assign trial = rem_sh - {1'b0, div_q};
	assign prod_ac = acc_q * sq_q;
	assign prod_ss = sq_q * sq_q;

	always_comb begin
		unique case (cmd.op)
			OP_WIT:  prod = {{W{1'b0}}, bor_q};
			OP_ACC:  prod = PW'(prod_ac);
			OP_SQ:   prod = PW'(prod_ss);
			default: prod = {{W{1'b0}}, bor_q};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
		end else if (busy_q && rcnt_q == CW'(1)) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= item.mode;
			m_q    <= m_in;
			bor_q  <= item.base_or_random;
			sq_q   <= item.base_or_random[W-1:0];
			acc_q  <= (m_in == W'(1)) ? '0 : W'(1);
			exp_q  <= item.mode ? 32'(m_in - W'(1)) : item.exponent;
			ecnt_q <= 6'(EXP_BITS);
		end
		if (cmd.shift_exp) begin
			exp_q  <= exp_q >> 1;
			ecnt_q <= ecnt_q - 6'd1;
		end
		if (cmd.start) begin
			num_q  <= prod;
			rem_q  <= '0;
			rcnt_q <= CW'(PW);
			op_q   <= cmd.op;
			div_q  <= (cmd.op == OP_WIT) ? m_q - W'(1) : m_q;
		end else if (busy_q) begin
			num_q  <= num_q << 1;
			rcnt_q <= rcnt_q - CW'(1);
			if (!trial[W]) rem_q <= trial;
			else rem_q <= rem_sh;
			if (rcnt_q == CW'(1)) begin
				unique case (op_q)
					OP_WIT:  sq_q  <= (!trial[W] ? trial[W-1:0] : rem_sh[W-1:0]) + W'(1);
					OP_ACC:  acc_q <= !trial[W] ? trial[W-1:0] : rem_sh[W-1:0];
					default: sq_q  <= !trial[W] ? trial[W-1:0] : rem_sh[W-1:0];
				endcase
			end
		end
		if (cmd.finish) begin
			result.bad_modulus    <= (m_q == '0);
			result.power_result   <= (m_q == '0) ? '0 : 32'(acc_q);
			result.probable_prime <= mode_q && (m_q > W'(1)) && (acc_q == W'(1));
		end
	end

	assign sts.busy = busy_q;
	assign sts.exp_bit = exp_q[0];
	assign sts.exp_done = (ecnt_q == 6'd0);
	assign sts.trivial = (m_q == '0) || (mode_q && m_q == W'(1));
endmodule
`default_nettype wire

### rtl/fmt_ctrl.sv
// controller: sequences reduction, multiply and square steps
`timescale 1ns / 1ps
`default_nettype none
module fmt_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	input  wire fmt_pkg::sts_t sts,
	output fmt_pkg::cmd_t      cmd
);
	import fmt_pkg::*;
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PREP = 3'd1;
	localparam logic [2:0] S_BIT  = 3'd2;
	localparam logic [2:0] S_WAIT = 3'd3;
	localparam logic [2:0] S_SQ   = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0] state_q, next;
	logic       outv_q, sq_phase_q, sq_phase_d;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = outv_q;

	always_comb begin
		cmd = '0;
		next = state_q;
		sq_phase_d = sq_phase_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					next = S_PREP;
				end
			end
			S_PREP: begin
				if (sts.trivial) begin
					next = S_DONE;
				end else begin
					cmd.start = 1'b1;
					cmd.op = OP_RED;
					sq_phase_d = 1'b0;
					next = S_WAIT;
				end
			end
			S_BIT: begin
				if (sts.exp_done) begin
					next = S_DONE;
				end else if (sts.exp_bit) begin
					cmd.start = 1'b1;
					cmd.op = OP_ACC;
					sq_phase_d = 1'b1;
					next = S_WAIT;
				end else begin
					next = S_SQ;
				end
			end
			S_SQ: begin
				cmd.start = 1'b1;
				cmd.op = OP_SQ;
				cmd.shift_exp = 1'b1;
				sq_phase_d = 1'b0;
				next = S_WAIT;
			end
			S_WAIT: begin
				if (!sts.busy) next = sq_phase_q ? S_SQ : S_BIT;
			end
			S_DONE: begin
				if (!outv_q || out_ready) begin
					cmd.finish = 1'b1;
					next = S_IDLE;
				end
			end
			default: next = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			outv_q <= 1'b0;
			sq_phase_q <= 1'b0;
		end else begin
			state_q <= next;
			sq_phase_q <= sq_phase_d;
			if (cmd.finish) outv_q <= 1'b1;
			else if (out_ready) outv_q <= 1'b0;
		end
	end
endmodule
`default_nettype wire

### rtl/fmt_witness.sv
// witness step: chooses between base reduction and witness derivation
`timescale 1ns / 1ps
`default_nettype none
module fmt_witness (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          load,
	input  wire logic          mode,
	input  wire fmt_pkg::cmd_t cmd_in,
	output fmt_pkg::cmd_t      cmd_out
);
	import fmt_pkg::*;
	logic mode_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mode_q <= 1'b0;
		else if (load) mode_q <= mode;
	end
	always_comb begin
		cmd_out = cmd_in;
		if (cmd_in.start && cmd_in.op == OP_RED && mode_q) cmd_out.op = OP_WIT;
	end
endmodule
`default_nettype wire

### rtl/fermat_modexp_tester.sv
// top level: modular exponentiation and single Fermat trial
`timescale 1ns / 1ps
`default_nettype none
// One item in, one result out. Every modular step (base reduction or witness
// derivation, multiply, square) loads a product into a shift-subtract remainder
// unit that works through all MOD_WIDTH+32 bits of it, started by the controller
// and waited on until no longer busy. An item needs one reduction plus 32
// squares and up to 32 multiplies; each zero bit of the exponent skips its
// multiply. A zero modulus or a candidate of one skips every step and goes
// straight to the result. One item is worked on at a time; the result register
// holds until taken.
module fermat_modexp_tester #(
	parameter int MOD_WIDTH = fmt_pkg::MOD_WIDTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire fmt_pkg::in_item_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output fmt_pkg::out_item_t      out_data
);
	import fmt_pkg::*;
	cmd_t cmd_raw, cmd;
	sts_t sts;

	fmt_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
		.sts, .cmd(cmd_raw)
	);
	fmt_witness u_wit (
		.clk, .arst_n, .load(cmd_raw.load), .mode(in_data.mode),
		.cmd_in(cmd_raw), .cmd_out(cmd)
	);
	fmt_datapath #(.MOD_WIDTH(MOD_WIDTH)) u_dp (
		.clk, .arst_n, .item(in_data), .cmd, .sts, .result(out_data)
	);
endmodule
`default_nettype wire

### rtl/fmt_checker.sv
// checker: port-level properties of the tester, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module fmt_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire fmt_pkg::out_item_t out_data
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");
	a_bad: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.bad_modulus |-> out_data.power_result == 32'd0
		&& !out_data.probable_prime)
		else $error("bad modulus with nonzero result");
	a_prime: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.probable_prime |-> out_data.power_result == 32'd1)
		else $error("pass without unit power");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second transfer taken while busy");
endmodule
bind fermat_modexp_tester fmt_checker u_chk (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);
`default_nettype wire

### test/fermat_modexp_tester_tb.sv
// testbench: modular power and Fermat trial checked against a built-in predictor
`timescale 1ns / 1ps
module fermat_modexp_tester_tb;
	import fmt_pkg::*;

	localparam int LIMIT = 6_000_000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_item_t in_data;
	logic out_valid;
	logic out_ready;
	out_item_t out_data;

	in_item_t pending_q[$];
	out_item_t expected_q[$];
	int mismatches;
	int cycles;
	int in_wait;
	int out_wait;
	int hold_cycles;
	bit stimulus_done;
	bit timed_out;

	fermat_modexp_tester u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [31:0] mod_power(logic [63:0] b, logic [31:0] e, logic [63:0] m);
		logic [63:0] acc;
		logic [63:0] sq;
		acc = 64'd1 % m;
		sq = b % m;
		for (int i = 0; i < 32; i++) begin
			if (e[i])
				acc = (acc * sq) % m;
			sq = (sq * sq) % m;
		end
		return acc[31:0];
	endfunction

	function automatic out_item_t fermat_result(in_item_t it);
		out_item_t r;
		logic [63:0] m;
		logic [63:0] w;
		r = '0;
		m = {32'd0, it.modulus};
		if (m == 0) begin
			r.bad_modulus = 1'b1;
		end else if (!it.mode) begin
			r.power_result = mod_power({32'd0, it.base_or_random}, it.exponent, m);
		end else if (m != 1) begin
			w = {32'd0, it.base_or_random} % (m - 1) + 1;
			r.power_result = mod_power(w, it.modulus - 32'd1, m);
			r.probable_prime = (r.power_result == 32'd1);
		end
		return r;
	endfunction

	function automatic logic [31:0] pick_modulus();
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, 3);
			1: return 32'hFFFF_FFFF - $urandom_range(0, 8);
			2: return $urandom_range(4, 1000);
			3: return 32'd2147483647;
			4: return 32'd561;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [31:0] pick_exponent();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 3);
			1: return 32'hFFFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	task automatic add_item(logic md, logic [31:0] b, logic [31:0] e, logic [31:0] m);
		in_item_t it;
		it.mode = md;
		it.base_or_random = b;
		it.exponent = e;
		it.modulus = m;
		pending_q.push_back(it);
	endtask

	initial begin
		add_item(1'b0, 32'd7, 32'd5, 32'd0);
		add_item(1'b1, 32'd7, 32'd5, 32'd0);
		add_item(1'b0, 32'd12345, 32'd77, 32'd1);
		add_item(1'b1, 32'hFFFF_FFFF, 32'd0, 32'd1);
		add_item(1'b1, 32'hDEAD_BEEF, 32'd0, 32'd2);
		add_item(1'b0, 32'd9, 32'd0, 32'd13);
		add_item(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_item(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFB);
		add_item(1'b0, 32'd0, 32'd0, 32'hFFFF_FFFF);
		add_item(1'b0, 32'd0, 32'd3, 32'd97);
		add_item(1'b0, 32'd1000, 32'd3, 32'd7);
		add_item(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFB);
		add_item(1'b1, 32'd0, 32'd0, 32'd2147483647);
		add_item(1'b1, 32'd1, 32'd0, 32'd561);
		add_item(1'b1, 32'd5, 32'd0, 32'd3);
		add_item(1'b1, 32'd123, 32'd0, 32'd4);
		add_item(1'b1, 32'h8000_0000, 32'h5555_5555, 32'hFFFF_FFFF);
		add_item(1'b0, 32'hAAAA_AAAA, 32'h8000_0000, 32'h8000_0000);
		for (int i = 0; i < 122; i++)
			add_item($urandom_range(0, 1), $urandom(), pick_exponent(), pick_modulus());
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			in_wait <= $urandom_range(0, 15);
		end else if (in_valid && !in_ready) begin
		end else if (in_wait > 0) begin
			in_valid <= 1'b0;
			in_wait <= in_wait - 1;
		end else if (pending_q.size() > 0) begin
			if (in_valid)
				expected_q.push_back(fermat_result(in_data));
			in_data <= pending_q.pop_front();
			in_valid <= 1'b1;
			in_wait <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15);
		end else begin
			if (in_valid)
				expected_q.push_back(fermat_result(in_data));
			in_valid <= 1'b0;
			stimulus_done <= 1'b1;
		end
	end

	// the driver only records a transfer when it moves on; catch the idle case too
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready && in_wait > 0)
			expected_q.push_back(fermat_result(in_data));
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_wait <= 0;
			hold_cycles <= 0;
		end else begin
			if (cycles == 40000 && hold_cycles == 0)
				hold_cycles <= 30000;
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected transfer: %h", out_data);
				end else begin
					out_item_t exp_r;
					exp_r = expected_q.pop_front();
					if (exp_r !== out_data) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected power %h prime %b bad %b, got power %h prime %b bad %b",
								exp_r.power_result, exp_r.probable_prime, exp_r.bad_modulus,
								out_data.power_result, out_data.probable_prime,
								out_data.bad_modulus);
					end
				end
			end
			if (hold_cycles > 1) begin
				hold_cycles <= hold_cycles - 1;
				out_ready <= 1'b0;
			end else if (out_wait > 0) begin
				out_wait <= out_wait - 1;
				out_ready <= 1'b0;
			end else if (out_valid && out_ready) begin
				out_wait <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15);
				out_ready <= 1'b0;
			end else begin
				if (hold_cycles == 1)
					hold_cycles <= -1;
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT)
			timed_out <= 1'b1;
	end

	initial begin
		cycles = 0;
		mismatches = 0;
		stimulus_done = 1'b0;
		timed_out = 1'b0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		#0.5 arst_n = 1'b1;
		while (!((stimulus_done && expected_q.size() == 0 && !in_valid) || timed_out))
			@(posedge clk);
		if (!timed_out) begin
			repeat (100) @(posedge clk);
			if (out_valid) begin
				mismatches++;
				$display("result left without expectation");
			end
		end
		if (timed_out) begin
			$display("fermat_modexp_tester_tb failed");
		end else if (mismatches == 0) begin
			$display("fermat_modexp_tester_tb passed");
		end else begin
			$display("fermat_modexp_tester_tb failed");
		end
		$finish;
	end
endmodule

### filelist.f
rtl/fmt_pkg.sv
rtl/fmt_datapath.sv
rtl/fmt_ctrl.sv
rtl/fmt_witness.sv
rtl/fermat_modexp_tester.sv
rtl/fmt_checker.sv
test/fermat_modexp_tester_tb.sv
